### hw/rtl/vm_instruction_execute_top_defines.svh
// assertion macros for the instruction executor
`ifndef VM_INSTRUCTION_EXECUTE_TOP_DEFINES_SVH
`define VM_INSTRUCTION_EXECUTE_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define VMX_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define VMX_ASSERT_RST(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define VMX_ASSERT(label, clk, rst_n, prop)
`define VMX_ASSERT_RST(label, clk, prop)
`endif
`endif

### hw/rtl/vmx_pkg.sv
package vmx_pkg;
    localparam logic [7:0] OP_MOVI = 8'h3f, OP_MOV = 8'h40, OP_PUSHI = 8'h19, OP_PUSH = 8'h12,
        OP_POP = 8'h9d, OP_ANDI = 8'hde, OP_AND = 8'hda, OP_ORI = 8'hb7, OP_OR = 8'hb2,
        OP_XORI = 8'hc1, OP_XOR = 8'hc9, OP_NOT = 8'h56, OP_ADDI = 8'h05, OP_ADD = 8'h0b,
        OP_SUBI = 8'h2f, OP_SUB = 8'h2c, OP_MULI = 8'h3d, OP_MUL = 8'h39, OP_DIVI = 8'h44,
        OP_DIV = 8'h47, OP_MODI = 8'h66, OP_MOD = 8'h60, OP_CMPI = 8'he9, OP_CMP = 8'hee,
        OP_JMP = 8'hfe, OP_JZ = 8'hf0, OP_JNZ = 8'hf1, OP_JE = 8'hf2, OP_JNE = 8'hf3,
        OP_JL = 8'hf4, OP_JLE = 8'hf5, OP_JG = 8'hf6, OP_JGE = 8'hf7, OP_CALL = 8'h99;
    localparam logic [3:0] RET_OFS = 4'd9;
    typedef enum logic [2:0] {
        F_OK = 3'd0, F_OVER = 3'd1, F_UNDER = 3'd2, F_TARGET = 3'd3,
        F_DIVZERO = 3'd4, F_REG = 3'd5, F_OPCODE = 3'd6
    } t_fault;
    typedef enum logic [3:0] {
        K_MOVE, K_AND, K_OR, K_XOR, K_ADD, K_SUB, K_MUL, K_DIV, K_MOD, K_CMP,
        K_NOT, K_PUSH, K_POP, K_JUMP, K_CALL, K_BAD
    } t_kind;
    typedef struct packed {
        t_kind       kind;
        logic        regsrc;
        logic [7:0]  op;
        logic [63:0] a;
        logic [63:0] b;
        logic [11:0] ia;
    } t_cmd;
    typedef enum logic [2:0] {S_IDLE, S_READ, S_MUL, S_DIV, S_EXEC, S_OUT} t_state;
    typedef struct packed {
        logic        jump_taken;
        logic [11:0] next_addr;
        logic [63:0] written_value;
        t_fault      fault;
    } t_res;
endpackage

### hw/rtl/vmx_ram.sv
module vmx_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### hw/rtl/vmx_front.sv
module vmx_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    output logic           o_full,
    input  logic [7:0]     i_req_type,
    input  logic [63:0]    i_arg_a,
    input  logic [63:0]    i_arg_b,
    input  logic [11:0]    i_instr_addr,
    output logic           o_valid,
    output vmx_pkg::t_cmd  o_cmd,
    input  logic           i_take
);
    // two-entry queue toward the back end
    vmx_pkg::t_cmd r_q [2];
    logic [1:0] r_cnt;
    logic       r_rd, r_wr;
    vmx_pkg::t_cmd n_cmd;
    logic acc, tk;

    always_comb begin
        n_cmd.op = i_req_type;
        n_cmd.a = i_arg_a;
        n_cmd.b = i_arg_b;
        n_cmd.ia = i_instr_addr;
        n_cmd.regsrc = 1'b0;
        unique case (i_req_type)
            vmx_pkg::OP_MOVI: n_cmd.kind = vmx_pkg::K_MOVE;
            vmx_pkg::OP_MOV: begin n_cmd.kind = vmx_pkg::K_MOVE; n_cmd.regsrc = 1'b1; end
            vmx_pkg::OP_ANDI: n_cmd.kind = vmx_pkg::K_AND;
            vmx_pkg::OP_AND: begin n_cmd.kind = vmx_pkg::K_AND; n_cmd.regsrc = 1'b1; end
            vmx_pkg::OP_ORI: n_cmd.kind = vmx_pkg::K_OR;
            vmx_pkg::OP_OR: begin n_cmd.kind = vmx_pkg::K_OR; n_cmd.regsrc = 1'b1; end
            vmx_pkg::OP_XORI: n_cmd.kind = vmx_pkg::K_XOR;
            vmx_pkg::OP_XOR: begin n_cmd.kind = vmx_pkg::K_XOR; n_cmd.regsrc = 1'b1; end
            vmx_pkg::OP_ADDI: n_cmd.kind = vmx_pkg::K_ADD;
            vmx_pkg::OP_ADD: begin n_cmd.kind = vmx_pkg::K_ADD; n_cmd.regsrc = 1'b1; end
            vmx_pkg::OP_SUBI: n_cmd.kind = vmx_pkg::K_SUB;
            vmx_pkg::OP_SUB: begin n_cmd.kind = vmx_pkg::K_SUB; n_cmd.regsrc = 1'b1; end
            vmx_pkg::OP_MULI: n_cmd.kind = vmx_pkg::K_MUL;
            vmx_pkg::OP_MUL: begin n_cmd.kind = vmx_pkg::K_MUL; n_cmd.regsrc = 1'b1; end
            vmx_pkg::OP_DIVI: n_cmd.kind = vmx_pkg::K_DIV;
            vmx_pkg::OP_DIV: begin n_cmd.kind = vmx_pkg::K_DIV; n_cmd.regsrc = 1'b1; end
            vmx_pkg::OP_MODI: n_cmd.kind = vmx_pkg::K_MOD;
            vmx_pkg::OP_MOD: begin n_cmd.kind = vmx_pkg::K_MOD; n_cmd.regsrc = 1'b1; end
            vmx_pkg::OP_CMPI: n_cmd.kind = vmx_pkg::K_CMP;
            vmx_pkg::OP_CMP: begin n_cmd.kind = vmx_pkg::K_CMP; n_cmd.regsrc = 1'b1; end
            vmx_pkg::OP_NOT: n_cmd.kind = vmx_pkg::K_NOT;
            vmx_pkg::OP_PUSHI, vmx_pkg::OP_PUSH: n_cmd.kind = vmx_pkg::K_PUSH;
            vmx_pkg::OP_POP: n_cmd.kind = vmx_pkg::K_POP;
            vmx_pkg::OP_JMP, vmx_pkg::OP_JZ, vmx_pkg::OP_JNZ, vmx_pkg::OP_JE,
            vmx_pkg::OP_JNE, vmx_pkg::OP_JL, vmx_pkg::OP_JLE, vmx_pkg::OP_JG,
            vmx_pkg::OP_JGE: n_cmd.kind = vmx_pkg::K_JUMP;
            vmx_pkg::OP_CALL: n_cmd.kind = vmx_pkg::K_CALL;
            default: n_cmd.kind = vmx_pkg::K_BAD;
        endcase
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_q[r_rd];
    assign acc = i_push && !o_full;
    assign tk  = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
        end else begin
            if (acc) r_wr <= ~r_wr;
            if (tk) r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, acc} - {1'b0, tk};
        end
        if (acc) r_q[r_wr] <= n_cmd;
    end
endmodule

### hw/rtl/vmx_back.sv
module vmx_back #(
    parameter int NUM_REGS  = 16,
    parameter int MEM_BYTES = 4096
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [12:0]   i_mem_limit,
    input  logic          i_valid,
    input  vmx_pkg::t_cmd i_cmd,
    output logic          o_take,
    output logic          o_res_valid,
    output vmx_pkg::t_res o_res,
    input  logic          i_res_take
);
    localparam int RW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int SW = $clog2(MEM_BYTES / 8);
    localparam int PW = $clog2(MEM_BYTES) + 1;

    vmx_pkg::t_state r_st, n_st;
    vmx_pkg::t_cmd   r_c;
    logic [63:0] r_reg [NUM_REGS];
    logic [63:0] r_cmp;
    logic [PW-1:0] r_sp;
    logic [63:0] r_d, r_s, r_acc, r_rem, r_quo;
    logic [6:0]  r_cnt;
    logic        r_rv;
    vmx_pkg::t_res r_res, n_res;
    logic [63:0] stk_rd;
    logic        st_we;
    logic [63:0] st_wd;

    logic [PW:0] lim;
    logic a_bad, b_bad;
    logic [RW-1:0] ai, bi;
    assign lim = (int'(i_mem_limit) > MEM_BYTES) ? (PW+1)'(MEM_BYTES)
                 : (PW+1)'(i_mem_limit);
    assign a_bad = r_c.a >= 64'(NUM_REGS);
    assign b_bad = r_c.b >= 64'(NUM_REGS);
    assign ai = r_c.a[RW-1:0];
    assign bi = r_c.b[RW-1:0];

    vmx_ram #(.WIDTH(64), .DEPTH(MEM_BYTES / 8)) u_stack (
        .i_clk(i_clk), .i_we(st_we), .i_waddr(SW'((r_sp - PW'(8)) >> 3)),
        .i_wdata(st_wd), .i_raddr(r_sp[SW+2:3]), .o_rdata(stk_rd)
    );

    assign o_take = (r_st == vmx_pkg::S_IDLE) && !r_rv;
    assign o_res_valid = r_rv;
    assign o_res = r_res;

    // restoring divide step
    logic [64:0] trial;
    assign trial = {r_rem[63:0], r_d[63]} - {1'b0, r_s};

    logic neg, zer, cond;
    logic push_ovr, push_und, pop_und;
    assign neg = r_cmp[63];
    assign zer = (r_cmp == 64'd0);
    assign push_ovr = r_sp < PW'(8);
    assign push_und = {1'b0, r_sp} > lim;
    assign pop_und  = ({1'b0, r_sp} + (PW+1)'(8)) > lim;

    always_comb begin
        unique case (r_c.op)
            vmx_pkg::OP_JZ, vmx_pkg::OP_JE: cond = zer;
            vmx_pkg::OP_JNZ, vmx_pkg::OP_JNE: cond = !zer;
            vmx_pkg::OP_JL: cond = neg;
            vmx_pkg::OP_JLE: cond = neg || zer;
            vmx_pkg::OP_JG: cond = !neg && !zer;
            vmx_pkg::OP_JGE: cond = !neg;
            default: cond = 1'b1;
        endcase
    end

    always_comb begin
        unique case (r_st)
            vmx_pkg::S_IDLE: n_st = (i_valid && !r_rv) ? vmx_pkg::S_READ : vmx_pkg::S_IDLE;
            vmx_pkg::S_READ: begin
                if (r_c.kind == vmx_pkg::K_MUL && !a_bad && !(r_c.regsrc && b_bad))
                    n_st = vmx_pkg::S_MUL;
                else if ((r_c.kind == vmx_pkg::K_DIV || r_c.kind == vmx_pkg::K_MOD)
                         && !a_bad && !(r_c.regsrc && b_bad))
                    n_st = vmx_pkg::S_DIV;
                else n_st = vmx_pkg::S_EXEC;
            end
            vmx_pkg::S_MUL: n_st = (r_cnt == 7'd3) ? vmx_pkg::S_EXEC : vmx_pkg::S_MUL;
            vmx_pkg::S_DIV: n_st = (r_cnt == 7'd64 || r_s == 64'd0) ? vmx_pkg::S_EXEC
                                   : vmx_pkg::S_DIV;
            vmx_pkg::S_EXEC: n_st = vmx_pkg::S_IDLE;
            default: n_st = vmx_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_res = '0;
        n_res.fault = vmx_pkg::F_OK;
        st_we = 1'b0;
        st_wd = r_s;
        if (r_st == vmx_pkg::S_EXEC) begin
            priority case (r_c.kind)
                vmx_pkg::K_MOVE, vmx_pkg::K_AND, vmx_pkg::K_OR, vmx_pkg::K_XOR,
                vmx_pkg::K_ADD, vmx_pkg::K_SUB, vmx_pkg::K_MUL, vmx_pkg::K_DIV,
                vmx_pkg::K_MOD, vmx_pkg::K_CMP: begin
                    if (a_bad || (r_c.regsrc && b_bad)) n_res.fault = vmx_pkg::F_REG;
                    else begin
                        unique case (r_c.kind)
                            vmx_pkg::K_MOVE: n_res.written_value = r_s;
                            vmx_pkg::K_AND: n_res.written_value = r_d & r_s;
                            vmx_pkg::K_OR: n_res.written_value = r_d | r_s;
                            vmx_pkg::K_XOR: n_res.written_value = r_d ^ r_s;
                            vmx_pkg::K_ADD: n_res.written_value = r_d + r_s;
                            vmx_pkg::K_MUL: n_res.written_value = r_acc;
                            vmx_pkg::K_DIV: n_res.written_value = r_quo;
                            vmx_pkg::K_MOD: n_res.written_value = r_rem;
                            default: n_res.written_value = r_d - r_s;
                        endcase
                        if ((r_c.kind == vmx_pkg::K_DIV || r_c.kind == vmx_pkg::K_MOD)
                            && r_s == 64'd0) begin
                            n_res.fault = vmx_pkg::F_DIVZERO;
                            n_res.written_value = '0;
                        end
                    end
                end
                vmx_pkg::K_NOT: begin
                    if (a_bad) n_res.fault = vmx_pkg::F_REG;
                    else n_res.written_value = ~r_d;
                end
                vmx_pkg::K_PUSH: begin
                    if (r_c.op == vmx_pkg::OP_PUSH && a_bad) n_res.fault = vmx_pkg::F_REG;
                    else if (push_ovr) n_res.fault = vmx_pkg::F_OVER;
                    else if (push_und) n_res.fault = vmx_pkg::F_UNDER;
                    else begin
                        n_res.written_value = (r_c.op == vmx_pkg::OP_PUSH) ? r_d : r_c.a;
                        st_wd = n_res.written_value;
                        st_we = 1'b1;
                    end
                end
                vmx_pkg::K_POP: begin
                    if (a_bad) n_res.fault = vmx_pkg::F_REG;
                    else if (pop_und) n_res.fault = vmx_pkg::F_UNDER;
                    else n_res.written_value = stk_rd;
                end
                vmx_pkg::K_JUMP: begin
                    if (r_c.a >= 64'(lim)) n_res.fault = vmx_pkg::F_TARGET;
                    else if (cond) begin
                        n_res.jump_taken = 1'b1;
                        n_res.next_addr = r_c.a[11:0];
                    end
                end
                vmx_pkg::K_CALL: begin
                    if (r_c.a >= 64'(lim)) n_res.fault = vmx_pkg::F_TARGET;
                    else if (push_ovr) n_res.fault = vmx_pkg::F_OVER;
                    else if (push_und) n_res.fault = vmx_pkg::F_UNDER;
                    else if (({1'b0, r_c.ia} + 13'(vmx_pkg::RET_OFS)) > 13'(lim))
                        n_res.fault = vmx_pkg::F_TARGET;
                    else begin
                        n_res.written_value = 64'({1'b0, r_c.ia} + 13'(vmx_pkg::RET_OFS));
                        n_res.jump_taken = 1'b1;
                        n_res.next_addr = r_c.a[11:0];
                        st_wd = n_res.written_value;
                        st_we = 1'b1;
                    end
                end
                default: n_res.fault = vmx_pkg::F_OPCODE;
            endcase
        end
    end

    logic ok_exec;
    assign ok_exec = (r_st == vmx_pkg::S_EXEC) && (n_res.fault == vmx_pkg::F_OK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= vmx_pkg::S_IDLE;
            r_rv  <= 1'b0;
            r_cmp <= '0;
            r_sp  <= PW'(MEM_BYTES);
            for (int i = 0; i < NUM_REGS; i++) r_reg[i] <= '0;
        end else begin
            r_st <= n_st;
            if (r_rv && i_res_take) r_rv <= 1'b0;
            if (r_st == vmx_pkg::S_EXEC) r_rv <= 1'b1;
            if (ok_exec) begin
                unique case (r_c.kind)
                    vmx_pkg::K_CMP: r_cmp <= n_res.written_value;
                    vmx_pkg::K_JUMP: ;
                    vmx_pkg::K_PUSH, vmx_pkg::K_CALL: r_sp <= r_sp - PW'(8);
                    vmx_pkg::K_POP: begin
                        r_sp <= r_sp + PW'(8);
                        r_reg[ai] <= n_res.written_value;
                    end
                    default: r_reg[ai] <= n_res.written_value;
                endcase
            end
        end
        if (r_st == vmx_pkg::S_EXEC) r_res <= n_res;
        if (o_take && i_valid) r_c <= i_cmd;
        unique case (r_st)
            vmx_pkg::S_READ: begin
                r_d   <= r_reg[ai];
                r_s   <= r_c.regsrc ? r_reg[bi] : r_c.b;
                r_cnt <= '0;
                r_acc <= '0;
                r_rem <= '0;
            end
            vmx_pkg::S_MUL: begin
                // 32x32 partial products; the high x high term is dropped
                unique case (r_cnt[1:0])
                    2'd0: r_acc <= r_acc + 64'(r_d[31:0] * r_s[31:0]);
                    2'd1: r_acc <= r_acc + {32'(r_d[63:32] * r_s[31:0]), 32'd0};
                    2'd2: r_acc <= r_acc + {32'(r_d[31:0] * r_s[63:32]), 32'd0};
                    default: ;
                endcase
                r_cnt <= r_cnt + 7'd1;
            end
            vmx_pkg::S_DIV: begin
                if (r_cnt != 7'd64) begin
                    if (!trial[64]) begin
                        r_rem <= trial[63:0];
                        r_quo <= {r_quo[62:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[62:0], r_d[63]};
                        r_quo <= {r_quo[62:0], 1'b0};
                    end
                    r_d <= {r_d[62:0], 1'b0};
                    r_cnt <= r_cnt + 7'd1;
                end
            end
            default: ;
        endcase
    end
endmodule

### hw/rtl/vm_instruction_execute_top.sv
// the back end works on one command at a time and takes another only once the
// result has been popped; the front queue holds up to two commands meanwhile;
// div and mod use the serial divider (one quotient bit a cycle), mul the 4-step
// 32x32 multiplier
// reset: synchronous active low; registers and compare word to zero,
// stack pointer and mem_limit to MEM_BYTES; stack words undefined until pushed
`include "vm_instruction_execute_top_defines.svh"
module vm_instruction_execute_top #(
    parameter int NUM_REGS  = 16,
    parameter int MEM_BYTES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [12:0] i_cfg_wdata,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_req_type,
    input  logic [63:0] i_arg_a,
    input  logic [63:0] i_arg_b,
    input  logic [11:0] i_instr_addr,
    output logic        empty,
    input  logic        pop,
    output logic        o_jump_taken,
    output logic [11:0] o_next_addr,
    output logic [63:0] o_written_value,
    output logic [2:0]  o_fault
);
    logic [12:0] r_mem_limit;
    logic q_valid, q_take, rv;
    vmx_pkg::t_cmd q_cmd;
    vmx_pkg::t_res res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_mem_limit <= 13'(MEM_BYTES);
        else if (i_cfg_we) r_mem_limit <= i_cfg_wdata;
    end

    vmx_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .o_full(full),
        .i_req_type(i_req_type), .i_arg_a(i_arg_a), .i_arg_b(i_arg_b),
        .i_instr_addr(i_instr_addr), .o_valid(q_valid), .o_cmd(q_cmd), .i_take(q_take)
    );

    vmx_back #(.NUM_REGS(NUM_REGS), .MEM_BYTES(MEM_BYTES)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_mem_limit(r_mem_limit),
        .i_valid(q_valid), .i_cmd(q_cmd), .o_take(q_take),
        .o_res_valid(rv), .o_res(res), .i_res_take(pop)
    );

    assign empty = !rv;
    assign o_jump_taken = res.jump_taken;
    assign o_next_addr = res.next_addr;
    assign o_written_value = res.written_value;
    assign o_fault = res.fault;

    `VMX_ASSERT(a_fault_clears, i_clk, i_rst_n, (!empty && o_fault != vmx_pkg::F_OK) |-> (o_written_value == 64'd0 && !o_jump_taken))
    `VMX_ASSERT(a_no_jump_addr, i_clk, i_rst_n, (!empty && !o_jump_taken) |-> (o_next_addr == 12'd0))
    `VMX_ASSERT(a_hold_result, i_clk, i_rst_n, (!empty && !pop) |=> (!empty && $stable(o_written_value)))
endmodule
